[src/typed_parameter_store_defines.svh]
// ----------------------------------------------------------------------------
// typed_parameter_store_defines.svh
// Assertion macros used by the typed parameter store port checks.
// ----------------------------------------------------------------------------
`ifndef TYPED_PARAMETER_STORE_DEFINES_SVH
`define TYPED_PARAMETER_STORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tps assertion failed");

// next-cycle implication, checked out of reset
`define TPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tps assertion failed");

`endif

[src/tps_pkg.sv]
// ----------------------------------------------------------------------------
// tps_pkg
// Types, codes and helpers of the typed parameter store.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned ID_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_GET  = 2'd1,
    KIND_SET  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_TYPE     = 3'd1,
    STAT_DUP      = 3'd2,
    STAT_CAP      = 3'd3,
    STAT_NOTFOUND = 3'd4,
    STAT_RDONLY   = 3'd5
  } status_t;

  localparam logic [2:0] TYPE_U8      = 3'd0;
  localparam logic [2:0] TYPE_U16     = 3'd1;
  localparam logic [2:0] TYPE_I8      = 3'd3;
  localparam logic [2:0] TYPE_I16     = 3'd4;
  localparam logic [2:0] TYPE_INVALID = 3'd7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        load_first;
    logic [15:0] item_id;
    logic [2:0]  value_type;
    logic        writable;
    logic [31:0] write_value;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] read_value;
    logic [2:0]  read_type;
  } result_t;

  // keep a value in the width of its type
  function automatic logic [31:0] fit_value(input logic [2:0] vtype, input logic [31:0] v);
    logic [31:0] r;
    case (vtype) inside
      TYPE_U8, TYPE_I8:   r = {24'd0, v[7:0]};
      TYPE_U16, TYPE_I16: r = {16'd0, v[15:0]};
      default:            r = v;
    endcase
    return r;
  endfunction

endpackage

[src/tps_ram.sv]
// ----------------------------------------------------------------------------
// tps_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/typed_parameter_store.sv]
// ----------------------------------------------------------------------------
// typed_parameter_store
// Store of typed parameters with load, get and set requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req (req_valid/req_ready), results leave on rsp
//   (rsp_valid/rsp_ready); every request gives exactly one result.
//   kind LOAD appends an entry (load_first empties the store first), GET
//   looks an entry up by id, SET replaces the value of a writable entry.
//   Each request passes the states CHECK, SCAN and DONE; loads refused
//   in CHECK and the spare kind skip SCAN. The id lookup walks the
//   entry RAM one read per cycle through a single comparator and stops
//   on a hit or when all entries below the fill count are compared.
//   req_ready is high only while no request is in work; it comes back
//   with rsp_valid, so no new request is taken before the result of
//   the last one is posted.
//   The result sits in an output register; a stalled receiver holds it
//   there and the block stops taking requests once a second result is
//   finished and cannot be posted.
//   Reset empties the store and clears the failed-batch mark; RAM
//   contents are not cleared, entries at or above the fill count are
//   never read.
// ----------------------------------------------------------------------------
module typed_parameter_store
  import tps_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned ID_BITS  = ID_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  request_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output result_t  rsp
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = ID_BITS + 3 + 1 + 32;
  localparam logic [CW-1:0] CAP_FULL = CW'(CAPACITY);

  state_t        state, state_next;
  request_t      r, r_next;
  logic [CW-1:0] count, count_next;
  logic          failed, failed_next;
  logic [CW-1:0] ptr, ptr_next;
  logic          pend, pend_next;
  logic [AW-1:0] pend_idx, pend_idx_next;
  result_t       res, res_next;
  logic          rsp_valid_next;
  result_t       rsp_next;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic [47:0]        id_wide;
  logic [ID_BITS-1:0] req_id;
  logic [ID_BITS-1:0] rd_id;
  logic [2:0]         rd_type;
  logic               rd_wr;
  logic [31:0]        rd_val;
  logic               hit;

  assign id_wide = {32'd0, r.item_id};
  assign req_id  = id_wide[ID_BITS-1:0];
  assign rd_id   = ram_rdata[EW-1 -: ID_BITS];
  assign rd_type = ram_rdata[35:33];
  assign rd_wr   = ram_rdata[32];
  assign rd_val  = ram_rdata[31:0];
  assign hit     = pend && (rd_id == req_id);

  assign req_ready = (state == S_IDLE);

  tps_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ptr[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      failed    <= 1'b0;
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      failed    <= failed_next;
      rsp_valid <= rsp_valid_next;
      pend      <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    r        <= r_next;
    ptr      <= ptr_next;
    pend_idx <= pend_idx_next;
    res      <= res_next;
    rsp      <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    r_next         = r;
    count_next     = count;
    failed_next    = failed;
    ptr_next       = ptr;
    pend_next      = pend;
    pend_idx_next  = pend_idx;
    res_next       = res;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && !rsp_ready;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = count[AW-1:0];
    ram_wdata      = {req_id, r.value_type, r.writable, fit_value(r.value_type, r.write_value)};

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          r_next     = req;
          state_next = S_CHECK;
          if (req.kind == KIND_LOAD && req.load_first) begin
            count_next  = '0;
            failed_next = 1'b0;
          end
        end
      end

      S_CHECK: begin
        ptr_next   = '0;
        pend_next  = 1'b0;
        res_next   = '0;
        state_next = S_SCAN;
        case (r.kind)
          KIND_LOAD: begin
            if (failed || count == CAP_FULL) begin
              res_next.status = STAT_CAP;
              count_next      = '0;
              failed_next     = 1'b1;
              state_next      = S_DONE;
            end else if (r.value_type == TYPE_INVALID) begin
              res_next.status = STAT_TYPE;
              count_next      = '0;
              failed_next     = 1'b1;
              state_next      = S_DONE;
            end
          end
          KIND_GET, KIND_SET: ;
          default: state_next = S_DONE;
        endcase
      end

      S_SCAN: begin
        ram_re        = !hit && (ptr != count);
        pend_next     = ram_re;
        pend_idx_next = ptr[AW-1:0];
        if (ram_re) begin
          ptr_next = ptr + 1'b1;
        end
        if (hit) begin
          state_next = S_DONE;
          case (r.kind)
            KIND_LOAD: begin
              res_next.status = STAT_DUP;
              count_next      = '0;
              failed_next     = 1'b1;
            end
            KIND_GET: begin
              res_next.read_value = rd_val;
              res_next.read_type  = rd_type;
            end
            KIND_SET: begin
              if (r.value_type != rd_type) begin
                res_next.status = STAT_TYPE;
              end else if (!rd_wr) begin
                res_next.status = STAT_RDONLY;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pend_idx;
                ram_wdata = {rd_id, rd_type, rd_wr, fit_value(rd_type, r.write_value)};
              end
            end
            default: ;
          endcase
        end else if (!pend && ptr == count) begin
          state_next = S_DONE;
          if (r.kind == KIND_LOAD) begin
            ram_we     = 1'b1;
            count_next = count + 1'b1;
          end else begin
            res_next.status = STAT_NOTFOUND;
          end
        end
      end

      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next = 1'b1;
          rsp_next       = res;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

[src/tps_checker.sv]
// ----------------------------------------------------------------------------
// tps_port_checks
// Port-level checks of the typed parameter store, bound to the top level.
// ----------------------------------------------------------------------------
`include "typed_parameter_store_defines.svh"

module tps_port_checks
  import tps_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input request_t req,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input result_t  rsp
);

  `TPS_ASSERT_NEXT(a_rsp_valid_hold, rsp_valid && !rsp_ready, rsp_valid)
  `TPS_ASSERT_NEXT(a_rsp_data_hold, rsp_valid && !rsp_ready, $stable(rsp))
  `TPS_ASSERT_NOW(a_fail_fields_zero, rsp_valid && rsp.status != STAT_OK,
                  rsp.read_value == 32'd0 && rsp.read_type == 3'd0)
  `TPS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

endmodule

bind typed_parameter_store tps_port_checks u_tps_port_checks (.*);
